// ===== rtl/pfla_pkg.sv =====
// ============================================================================
// pfla_pkg: shared types and constants of the paged free-list allocator
// Request and response payloads, status codes, register indexes and the
// command and status groups between the controller and the datapath.
// ============================================================================
`default_nettype none

package pfla_pkg;

    localparam int DEF_MAX_PAGES       = 8;
    localparam int DEF_MAX_FREE_BLOCKS = 16;
    localparam int DEF_MAX_ALLOCS      = 64;

    localparam logic [31:0] RESET_PAGE_BYTES = 32'd65536;
    localparam logic [12:0] RESET_MIN_ALIGN  = 13'd16;

    // Configuration register indexes.
    localparam logic CFG_PAGE_BYTES = 1'b0;
    localparam logic CFG_MIN_ALIGN  = 1'b1;

    // Request function codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Response status codes.
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_NO_PAGE      = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL   = 3'd2;
    localparam logic [2:0] ST_LIST_FULL    = 3'd3;
    localparam logic [2:0] ST_UNKNOWN_FREE = 3'd4;

    typedef struct packed {
        logic        func;
        logic [31:0] req_size;
        logic [12:0] req_align;
        logic [2:0]  free_page;
        logic [31:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  out_page;
        logic [31:0] out_offset;
        logic [31:0] out_size;
    } t_rsp;

    typedef enum logic [4:0] {
        C_NONE,
        C_LOAD,
        C_PG_NEXT,
        C_FB_BEGIN,
        C_FB_STEP,
        C_NEW_PG,
        C_AT_BEGIN,
        C_AT_STEP,
        C_A_COMMIT,
        C_RM_WRITE,
        C_A_PUSH,
        C_F_BEGIN,
        C_F_STEP,
        C_F_RMSEL,
        C_F_FINISH,
        C_ERR,
        C_DELIVER
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] code;
    } t_ctl;

    typedef struct packed {
        logic func_free;
        logic over;
        logic pg_done;
        logic pg_ok;
        logic fc_zero;
        logic troom_ok;
        logic fb_last;
        logic fb_fit_now;
        logic bi_ok;
        logic fresh_ok;
        logic at_hit_now;
        logic at_free_now;
        logic free_ok;
        logic at_last;
        logic split;
        logic f_full;
        logic k_zero;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

// ===== rtl/pfla_dpath.sv =====
// ============================================================================
// pfla_dpath: allocator datapath
// Page table, per-page free-block memory, allocation table, scan counters,
// configuration registers and the response register.
// ============================================================================
`default_nettype none

module pfla_dpath
    import pfla_pkg::*;
#(
    parameter int MAX_PAGES       = DEF_MAX_PAGES,
    parameter int MAX_FREE_BLOCKS = DEF_MAX_FREE_BLOCKS,
    parameter int MAX_ALLOCS      = DEF_MAX_ALLOCS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_ctl        i_ctl,
    output t_stat       o_stat,
    input  t_req        i_req,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    output logic        o_rsp_valid,
    input  wire         i_rsp_ready,
    output t_rsp        o_rsp
);

    localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PGC_W = $clog2(MAX_PAGES + 1);
    localparam int FI_W  = $clog2(MAX_FREE_BLOCKS);
    localparam int FC_W  = $clog2(MAX_FREE_BLOCKS + 1);
    localparam int FB_D  = MAX_PAGES * MAX_FREE_BLOCKS;
    localparam int FBA_W = $clog2(FB_D);
    localparam int AI_W  = $clog2(MAX_ALLOCS);
    localparam int FS_W  = 32 + FI_W + 2;
    localparam int KP_W  = (PG_W > 3) ? PG_W : 3;

    typedef struct packed {
        logic [31:0] off;
        logic [31:0] size;
    } t_fblk;

    typedef struct packed {
        logic [PG_W-1:0] page;
        logic [31:0]     off;
        logic [31:0]     size;
    } t_arec;

    function automatic logic [FBA_W-1:0] fb_addr(input logic [PG_W-1:0] p,
                                                 input logic [FI_W-1:0] i);
        fb_addr = FBA_W'(int'(p) * MAX_FREE_BLOCKS + int'(i));
    endfunction

    // Configuration and control state.
    logic [31:0]     r_def_bytes;
    logic [12:0]     r_min_align;
    logic            r_pvalid [MAX_PAGES];
    logic [FC_W-1:0] r_fc     [MAX_PAGES];
    logic            r_avalid [MAX_ALLOCS];
    logic            r_out_valid;

    // Payload and working registers.
    logic            r_func;
    logic [2:0]      r_fpage;
    logic [31:0]     r_foff;
    logic [31:0]     r_aligned;
    logic            r_over;
    logic [PGC_W-1:0] r_page;
    logic            r_fresh;
    logic [31:0]     r_pbytes [MAX_PAGES];
    logic [31:0]     r_ptail  [MAX_PAGES];
    logic [31:0]     r_pused  [MAX_PAGES];
    logic [FI_W-1:0] r_idx;
    logic [FI_W-1:0] r_bi;
    logic            r_bi_ok;
    t_fblk           r_bi_blk;
    logic [31:0]     r_off;
    logic [AI_W-1:0] r_aidx;
    logic            r_hit;
    logic [AI_W-1:0] r_slot;
    logic            r_free_ok;
    logic [AI_W-1:0] r_free_slot;
    t_arec           r_hit_rec;
    logic [31:0]     r_fo;
    logic [FS_W-1:0] r_fs;
    logic [31:0]     r_asz;
    logic [FC_W-1:0] r_k;
    logic [FI_W-1:0] r_merge [MAX_FREE_BLOCKS];
    logic [FI_W-1:0] r_rm_idx;
    t_rsp            r_res;
    t_rsp            r_out;

    // Memories.
    t_fblk           m_fb [FB_D];
    t_fblk           r_fb_q;
    t_arec           m_at [MAX_ALLOCS];
    t_arec           r_at_q;

    logic [PG_W-1:0] pg;
    logic [FC_W-1:0] fc_cur;
    logic [FC_W-1:0] fc_m1;
    logic [FC_W-1:0] k_m1;
    logic [31:0]     tail_cur;
    logic [31:0]     used_cur;
    logic [31:0]     bytes_cur;
    logic [31:0]     rem;
    logic [31:0]     troom;
    logic            fresh_ok;
    logic [PG_W-1:0] fresh_pg;
    logic [12:0]     al_max;
    logic [12:0]     al_m0;
    logic [12:0]     al_m1;
    logic [12:0]     al_m2;
    logic [12:0]     al_m3;
    logic [12:0]     al_mask;
    logic [32:0]     al_full;
    logic [KP_W-1:0] key_pg;
    logic [31:0]     key_off;
    logic            at_hit_now;
    logic [AI_W-1:0] slot_w;
    logic [32:0]     bo_end;
    logic [FS_W-1:0] fo_end;
    logic            f_m_lo;
    logic            f_m_hi;
    logic            retract;
    logic            fb_we;
    logic [FBA_W-1:0] fb_waddr;
    t_fblk           fb_wdata;
    logic [31:0]     tail_base;
    logic [31:0]     used_base;

    assign pg        = r_page[PG_W-1:0];
    assign fc_cur    = r_fc[pg];
    assign fc_m1     = fc_cur - FC_W'(1);
    assign k_m1      = r_k - FC_W'(1);
    assign tail_cur  = r_ptail[pg];
    assign used_cur  = r_pused[pg];
    assign bytes_cur = r_pbytes[pg];
    assign rem       = (used_cur <= bytes_cur) ? bytes_cur - used_cur : 32'd0;
    assign troom     = (tail_cur <= bytes_cur) ? bytes_cur - tail_cur : 32'd0;

    always_comb begin
        fresh_ok = 1'b0;
        fresh_pg = '0;
        for (int p = MAX_PAGES - 1; p >= 0; p--) begin
            if (!r_pvalid[p]) begin
                fresh_ok = 1'b1;
                fresh_pg = PG_W'(p);
            end
        end
    end

    // Alignment is the next power of two at or above max(requested, minimum).
    always_comb begin
        al_max  = (i_req.req_align > r_min_align) ? i_req.req_align : r_min_align;
        al_m0   = (al_max == 13'd0) ? 13'd0 : al_max - 13'd1;
        al_m1   = al_m0 | (al_m0 >> 1);
        al_m2   = al_m1 | (al_m1 >> 2);
        al_m3   = al_m2 | (al_m2 >> 4);
        al_mask = al_m3 | (al_m3 >> 8);
        al_full = ({1'b0, i_req.req_size} + {20'd0, al_mask}) & ~{20'd0, al_mask};
    end

    assign key_pg     = r_func ? KP_W'(r_fpage) : KP_W'(pg);
    assign key_off    = r_func ? r_foff : r_off;
    assign at_hit_now = r_avalid[r_aidx] && (KP_W'(r_at_q.page) == key_pg)
                        && (r_at_q.off == key_off);
    assign slot_w     = r_hit ? r_slot : r_free_slot;

    assign bo_end  = {1'b0, r_fb_q.off} + {1'b0, r_fb_q.size};
    assign fo_end  = FS_W'(r_fo) + r_fs;
    assign f_m_lo  = (bo_end == {1'b0, r_fo});
    assign f_m_hi  = (FS_W'(r_fb_q.off) == fo_end);
    assign retract = (fo_end == FS_W'(tail_cur));

    assign tail_base = r_fresh ? 32'd0 : tail_cur;
    assign used_base = r_fresh ? 32'd0 : used_cur;

    always_comb begin
        o_stat.func_free   = r_func;
        o_stat.over        = r_over;
        o_stat.pg_done     = (r_page == PGC_W'(MAX_PAGES));
        o_stat.pg_ok       = r_pvalid[pg] && (rem >= r_aligned);
        o_stat.fc_zero     = (fc_cur == '0);
        o_stat.troom_ok    = (troom >= r_aligned);
        o_stat.fb_last     = ((FC_W'(r_idx) + FC_W'(1)) == fc_cur);
        o_stat.fb_fit_now  = (r_fb_q.size >= r_aligned);
        o_stat.bi_ok       = r_bi_ok;
        o_stat.fresh_ok    = fresh_ok;
        o_stat.at_hit_now  = at_hit_now;
        o_stat.at_free_now = !r_avalid[r_aidx];
        o_stat.free_ok     = r_free_ok;
        o_stat.at_last     = (r_aidx == AI_W'(MAX_ALLOCS - 1));
        o_stat.split       = (r_bi_blk.size > r_aligned);
        o_stat.f_full      = !retract && ((fc_cur - r_k) >= FC_W'(MAX_FREE_BLOCKS));
        o_stat.k_zero      = (r_k == '0);
        o_stat.out_busy    = r_out_valid && !i_rsp_ready;
    end

    // Free-block memory write port.
    always_comb begin
        fb_we    = 1'b0;
        fb_waddr = fb_addr(pg, r_rm_idx);
        fb_wdata = r_fb_q;
        case (i_ctl.cmd)
            C_RM_WRITE: begin
                fb_we = 1'b1;
            end
            C_A_PUSH: begin
                fb_we    = 1'b1;
                fb_waddr = fb_addr(pg, fc_cur[FI_W-1:0]);
                fb_wdata = '{off: r_bi_blk.off + r_aligned, size: r_bi_blk.size - r_aligned};
            end
            C_F_FINISH: begin
                fb_we    = !retract;
                fb_waddr = fb_addr(pg, fc_cur[FI_W-1:0]);
                fb_wdata = '{off: r_fo, size: r_fs[31:0]};
            end
            default: begin
                fb_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            m_fb[fb_waddr] <= fb_wdata;
        end
        r_fb_q <= m_fb[fb_addr(pg, r_idx)];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == C_A_COMMIT) begin
            m_at[slot_w] <= '{page: pg, off: r_off, size: r_aligned};
        end
        r_at_q <= m_at[r_aidx];
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_bytes <= RESET_PAGE_BYTES;
            r_min_align <= RESET_MIN_ALIGN;
            r_out_valid <= 1'b0;
            for (int p = 0; p < MAX_PAGES; p++) begin
                r_pvalid[p] <= 1'b0;
                r_fc[p]     <= '0;
            end
            for (int a = 0; a < MAX_ALLOCS; a++) begin
                r_avalid[a] <= 1'b0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PAGE_BYTES: r_def_bytes <= i_cfg_data;
                    CFG_MIN_ALIGN:  r_min_align <= i_cfg_data[12:0];
                    default:        r_def_bytes <= r_def_bytes;
                endcase
            end
            if (i_ctl.cmd == C_DELIVER) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_ctl.cmd)
                C_A_COMMIT: begin
                    r_avalid[slot_w] <= 1'b1;
                    if (r_fresh) begin
                        r_pvalid[pg] <= 1'b1;
                        r_fc[pg]     <= '0;
                    end
                end
                C_RM_WRITE: r_fc[pg] <= fc_m1;
                C_A_PUSH:   r_fc[pg] <= fc_cur + FC_W'(1);
                C_F_FINISH: begin
                    r_avalid[r_slot] <= 1'b0;
                    if (!retract) begin
                        r_fc[pg] <= fc_cur + FC_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmd == C_DELIVER) begin
            r_out <= r_res;
        end
        case (i_ctl.cmd)
            C_LOAD: begin
                r_func    <= i_req.func;
                r_fpage   <= i_req.free_page;
                r_foff    <= i_req.free_offset;
                r_aligned <= al_full[31:0];
                r_over    <= al_full[32];
                r_page    <= '0;
                r_fresh   <= 1'b0;
                r_bi_ok   <= 1'b0;
            end
            C_PG_NEXT: r_page <= r_page + PGC_W'(1);
            C_FB_BEGIN: begin
                r_idx   <= '0;
                r_bi_ok <= 1'b0;
            end
            C_FB_STEP: begin
                if (r_fb_q.size >= r_aligned) begin
                    r_bi     <= r_idx;
                    r_bi_ok  <= 1'b1;
                    r_bi_blk <= r_fb_q;
                end
                r_idx <= r_idx + FI_W'(1);
            end
            C_NEW_PG: begin
                r_page  <= PGC_W'(fresh_pg);
                r_fresh <= 1'b1;
                r_bi_ok <= 1'b0;
            end
            C_AT_BEGIN: begin
                r_off     <= r_bi_ok ? r_bi_blk.off : tail_base;
                r_aidx    <= '0;
                r_hit     <= 1'b0;
                r_free_ok <= 1'b0;
            end
            C_AT_STEP: begin
                if (at_hit_now) begin
                    r_hit     <= 1'b1;
                    r_slot    <= r_aidx;
                    r_hit_rec <= r_at_q;
                end else if (!r_avalid[r_aidx] && !r_free_ok) begin
                    r_free_ok   <= 1'b1;
                    r_free_slot <= r_aidx;
                end
                r_aidx <= r_aidx + AI_W'(1);
            end
            C_A_COMMIT: begin
                if (r_fresh) begin
                    r_pbytes[pg] <= (r_aligned < r_def_bytes) ? r_def_bytes : r_aligned;
                    r_ptail[pg]  <= tail_base;
                end
                if (!r_bi_ok) begin
                    r_ptail[pg] <= tail_base + r_aligned;
                end
                r_pused[pg] <= used_base + r_aligned;
                r_res       <= '{status: ST_OK, out_page: 3'(pg), out_offset: r_off,
                                 out_size: r_aligned};
                r_rm_idx    <= r_bi;
                r_idx       <= fc_m1[FI_W-1:0];
            end
            C_F_BEGIN: begin
                r_page <= PGC_W'(r_hit_rec.page);
                r_fo   <= r_hit_rec.off;
                r_fs   <= FS_W'(r_hit_rec.size);
                r_asz  <= r_hit_rec.size;
                r_k    <= '0;
                r_idx  <= '0;
            end
            C_F_STEP: begin
                if (f_m_lo) begin
                    r_fo <= r_fb_q.off;
                end
                if (f_m_lo || f_m_hi) begin
                    r_fs                   <= r_fs + FS_W'(r_fb_q.size);
                    r_merge[r_k[FI_W-1:0]] <= r_idx;
                    r_k                    <= r_k + FC_W'(1);
                end
                r_idx <= r_idx + FI_W'(1);
            end
            C_F_RMSEL: begin
                r_rm_idx <= r_merge[k_m1[FI_W-1:0]];
                r_k      <= k_m1;
                r_idx    <= fc_m1[FI_W-1:0];
            end
            C_F_FINISH: begin
                if (retract) begin
                    r_ptail[pg] <= r_fo;
                end
                r_pused[pg] <= used_cur - r_asz;
                r_res       <= '{status: ST_OK, out_page: r_fpage, out_offset: r_foff,
                                 out_size: r_asz};
            end
            C_ERR: begin
                r_res <= '{status: i_ctl.code, out_page: 3'd0, out_offset: 32'd0,
                           out_size: 32'd0};
            end
            default: r_page <= r_page;
        endcase
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

`default_nettype wire

// ===== rtl/pfla_ctrl.sv =====
// ============================================================================
// pfla_ctrl: allocator sequencer
// Steps the datapath through the page, free-block and allocation-table scans
// and the commit of one request at a time.
// ============================================================================
`default_nettype none

module pfla_ctrl
    import pfla_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_req_valid,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_ctl  o_ctl
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_A_PAGE,
        S_A_FBW,
        S_A_FBC,
        S_A_NXT,
        S_A_NEWPG,
        S_AT_BEGIN,
        S_AT_W,
        S_AT_C,
        S_A_COMMIT,
        S_RM_W,
        S_RM_WR,
        S_A_PUSH,
        S_F_BEGIN,
        S_F_PRE,
        S_F_W,
        S_F_C,
        S_F_DECIDE,
        S_F_RMSEL,
        S_F_FINISH,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_ctl.cmd  = C_NONE;
        o_ctl.code = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_ctl.cmd = C_LOAD;
                    n_state   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_stat.func_free) begin
                    n_state = S_AT_BEGIN;
                end else if (i_stat.over) begin
                    o_ctl.cmd  = C_ERR;
                    o_ctl.code = ST_NO_PAGE;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_A_PAGE;
                end
            end
            S_A_PAGE: begin
                if (i_stat.pg_done) begin
                    n_state = S_A_NEWPG;
                end else if (i_stat.pg_ok && !i_stat.fc_zero) begin
                    o_ctl.cmd = C_FB_BEGIN;
                    n_state   = S_A_FBW;
                end else if (i_stat.pg_ok && i_stat.troom_ok) begin
                    o_ctl.cmd = C_FB_BEGIN;
                    n_state   = S_AT_BEGIN;
                end else begin
                    o_ctl.cmd = C_PG_NEXT;
                end
            end
            S_A_FBW: n_state = S_A_FBC;
            S_A_FBC: begin
                o_ctl.cmd = C_FB_STEP;
                if (!i_stat.fb_last) begin
                    n_state = S_A_FBW;
                end else if (i_stat.troom_ok || i_stat.bi_ok || i_stat.fb_fit_now) begin
                    n_state = S_AT_BEGIN;
                end else begin
                    n_state = S_A_NXT;
                end
            end
            S_A_NXT: begin
                o_ctl.cmd = C_PG_NEXT;
                n_state   = S_A_PAGE;
            end
            S_A_NEWPG: begin
                if (i_stat.fresh_ok) begin
                    o_ctl.cmd = C_NEW_PG;
                    n_state   = S_AT_BEGIN;
                end else begin
                    o_ctl.cmd  = C_ERR;
                    o_ctl.code = ST_NO_PAGE;
                    n_state    = S_DONE;
                end
            end
            S_AT_BEGIN: begin
                o_ctl.cmd = C_AT_BEGIN;
                n_state   = S_AT_W;
            end
            S_AT_W: n_state = S_AT_C;
            S_AT_C: begin
                o_ctl.cmd = C_AT_STEP;
                if (!i_stat.at_hit_now && !i_stat.at_last) begin
                    n_state = S_AT_W;
                end else if (i_stat.func_free) begin
                    if (i_stat.at_hit_now) begin
                        n_state = S_F_BEGIN;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (i_stat.at_hit_now || i_stat.free_ok || i_stat.at_free_now) begin
                    n_state = S_A_COMMIT;
                end else begin
                    n_state = S_DONE;
                end
                if (i_stat.at_last && !i_stat.at_hit_now) begin
                    if (i_stat.func_free) begin
                        o_ctl.code = ST_UNKNOWN_FREE;
                        o_ctl.cmd  = C_ERR;
                    end else if (!i_stat.free_ok && !i_stat.at_free_now) begin
                        o_ctl.code = ST_TABLE_FULL;
                        o_ctl.cmd  = C_ERR;
                    end
                end
            end
            S_A_COMMIT: begin
                o_ctl.cmd = C_A_COMMIT;
                n_state   = i_stat.bi_ok ? S_RM_W : S_DONE;
            end
            S_RM_W: n_state = S_RM_WR;
            S_RM_WR: begin
                o_ctl.cmd = C_RM_WRITE;
                if (!i_stat.func_free) begin
                    n_state = i_stat.split ? S_A_PUSH : S_DONE;
                end else begin
                    n_state = i_stat.k_zero ? S_F_FINISH : S_F_RMSEL;
                end
            end
            S_A_PUSH: begin
                o_ctl.cmd = C_A_PUSH;
                n_state   = S_DONE;
            end
            S_F_BEGIN: begin
                o_ctl.cmd = C_F_BEGIN;
                n_state   = S_F_PRE;
            end
            S_F_PRE: n_state = i_stat.fc_zero ? S_F_DECIDE : S_F_W;
            S_F_W:   n_state = S_F_C;
            S_F_C: begin
                o_ctl.cmd = C_F_STEP;
                n_state   = i_stat.fb_last ? S_F_DECIDE : S_F_W;
            end
            S_F_DECIDE: begin
                if (i_stat.f_full) begin
                    o_ctl.cmd  = C_ERR;
                    o_ctl.code = ST_LIST_FULL;
                    n_state    = S_DONE;
                end else if (i_stat.k_zero) begin
                    n_state = S_F_FINISH;
                end else begin
                    n_state = S_F_RMSEL;
                end
            end
            S_F_RMSEL: begin
                o_ctl.cmd = C_F_RMSEL;
                n_state   = S_RM_W;
            end
            S_F_FINISH: begin
                o_ctl.cmd = C_F_FINISH;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_ctl.cmd = C_DELIVER;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/paged_free_list_allocator_unit.sv =====
// ============================================================================
// paged_free_list_allocator_unit: paged last-fit allocator with coalescing
// Top level: joins the sequencer and the datapath and exposes the request,
// response and configuration channels.
// ============================================================================
// Each request is handled alone, and a new one is taken as soon as the
// previous response has been loaded into the output register, even if that
// response has not been taken yet. An allocate request scans the pages in
// order and the free blocks of each page visited, then the allocation
// table, and then commits; a free scans the allocation table and the free
// blocks of its page and then removes each merged block. The cost of a
// request is set by the allocation-table scan, which reads one entry at a
// time through one memory read port, and by the free-block scans. All tables
// track occupancy in valid bits and fill counts, so no clearing pass runs
// after reset. The configuration port is always ready and must only be
// written while no request is outstanding.
`default_nettype none

module paged_free_list_allocator_unit
    import pfla_pkg::*;
#(
    parameter int MAX_PAGES       = DEF_MAX_PAGES,
    parameter int MAX_FREE_BLOCKS = DEF_MAX_FREE_BLOCKS,
    parameter int MAX_ALLOCS      = DEF_MAX_ALLOCS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_req_valid,
    output logic        o_req_ready,
    input  t_req        i_req,
    output logic        o_rsp_valid,
    input  wire         i_rsp_ready,
    output t_rsp        o_rsp,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [31:0] i_cfg_data
);

    t_ctl  ctl;
    t_stat stat;

    // Register writes never wait for the sequencer, so the port never stalls.
    assign o_cfg_ready = 1'b1;

    pfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    pfla_dpath #(
        .MAX_PAGES       (MAX_PAGES),
        .MAX_FREE_BLOCKS (MAX_FREE_BLOCKS),
        .MAX_ALLOCS      (MAX_ALLOCS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_stat      (stat),
        .i_req       (i_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    // Only one request is in flight: an accepted request blocks the next.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready) |=> !o_req_ready)
        else $error("request accepted while another is in progress");

    // Failed requests report zero page, offset and size.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.status != ST_OK) |->
        (o_rsp.out_page == 3'd0 && o_rsp.out_offset == 32'd0 && o_rsp.out_size == 32'd0))
        else $error("error response with nonzero fields");

    // A response is only produced at the end of processing a request.
    a_rsp_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(!o_req_ready))
        else $error("response appeared without a request being processed");

endmodule

`default_nettype wire

// ===== sim/pfla_checker.sv =====
// ============================================================================
// pfla_checker: response predictor and scoreboard for the paged allocator
// Watches the request, response and configuration channels, models the page
// and allocation tables, and compares each response with the oldest forecast.
// ============================================================================
`default_nettype none

module pfla_checker
    import pfla_pkg::*;
#(
    parameter int NP = DEF_MAX_PAGES,
    parameter int NF = DEF_MAX_FREE_BLOCKS,
    parameter int NA = DEF_MAX_ALLOCS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_req_valid,
    input  wire         i_req_ready,
    input  t_req        i_req,
    input  wire         i_rsp_valid,
    input  wire         i_rsp_ready,
    input  t_rsp        i_rsp,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire         i_cfg_index,
    input  wire  [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    logic [31:0] page_bytes_cfg;
    logic [12:0] min_align_cfg;

    bit          pg_open  [NP];
    logic [31:0] pg_size  [NP];
    logic [31:0] pg_tail  [NP];
    logic [31:0] pg_used  [NP];
    int          pg_holes [NP];
    logic [31:0] hole_off [NP][NF];
    logic [31:0] hole_len [NP][NF];

    bit          grant_live [NA];
    logic [2:0]  grant_page [NA];
    logic [31:0] grant_off  [NA];
    logic [31:0] grant_len  [NA];

    t_rsp        rsp_forecast_q[$];
    int          fails;

    function automatic void hole_drop(int p, int i);
        int n;
        n = pg_holes[p];
        if (n == 0 || i >= n) return;
        hole_off[p][i] = hole_off[p][n-1];
        hole_len[p][i] = hole_len[p][n-1];
        pg_holes[p] = n - 1;
    endfunction

    function automatic void hole_add(int p, logic [31:0] off, logic [31:0] len);
        int n;
        n = pg_holes[p];
        if (n >= NF) return;
        hole_off[p][n] = off;
        hole_len[p][n] = len;
        pg_holes[p] = n + 1;
    endfunction

    function automatic bit page_has_room(int p, logic [63:0] s);
        logic [63:0] rem, troom;
        rem   = (pg_used[p] <= pg_size[p]) ? 64'(pg_size[p] - pg_used[p]) : 64'd0;
        troom = (pg_tail[p] <= pg_size[p]) ? 64'(pg_size[p] - pg_tail[p]) : 64'd0;
        if (rem < s) return 1'b0;
        if (troom >= s) return 1'b1;
        for (int i = 0; i < pg_holes[p]; i++)
            if (64'(hole_len[p][i]) >= s) return 1'b1;
        return 1'b0;
    endfunction

    function automatic t_rsp grant(t_req r);
        t_rsp        y;
        logic [63:0] a, pw, sz, off;
        int          p, bi, slot;
        bit          found, fresh;
        logic [31:0] bsz;
        y = '0;
        a = (r.req_align > min_align_cfg) ? 64'(r.req_align) : 64'(min_align_cfg);
        pw = 64'd1;
        while (pw < a) pw = pw << 1;
        sz = (64'(r.req_size) + pw - 64'd1) & ~(pw - 64'd1);
        if (sz > 64'hFFFF_FFFF) begin
            y.status = ST_NO_PAGE;
            return y;
        end
        found = 1'b0;
        fresh = 1'b0;
        for (p = 0; p < NP; p++)
            if (pg_open[p] && page_has_room(p, sz)) begin
                found = 1'b1;
                break;
            end
        if (!found) begin
            for (p = 0; p < NP; p++)
                if (!pg_open[p]) break;
            if (p >= NP) begin
                y.status = ST_NO_PAGE;
                return y;
            end
            fresh = 1'b1;
        end
        // The last hole that fits wins.
        bi = -1;
        if (!fresh)
            for (int i = pg_holes[p]; i > 0; i--)
                if (64'(hole_len[p][i-1]) >= sz) begin
                    bi = i - 1;
                    break;
                end
        off = (bi >= 0) ? 64'(hole_off[p][bi]) : (fresh ? 64'd0 : 64'(pg_tail[p]));
        // A grant at an existing key reuses that table entry.
        slot = NA;
        for (int i = 0; i < NA; i++)
            if (grant_live[i] && grant_page[i] == 3'(p) && grant_off[i] == off[31:0]) begin
                slot = i;
                break;
            end
        if (slot == NA)
            for (int i = 0; i < NA; i++)
                if (!grant_live[i]) begin
                    slot = i;
                    break;
                end
        if (slot == NA) begin
            y.status = ST_TABLE_FULL;
            return y;
        end
        if (fresh) begin
            pg_open[p]  = 1'b1;
            pg_size[p]  = (sz < 64'(page_bytes_cfg)) ? page_bytes_cfg : sz[31:0];
            pg_tail[p]  = '0;
            pg_used[p]  = '0;
            pg_holes[p] = 0;
        end
        if (bi >= 0) begin
            bsz = hole_len[p][bi];
            hole_drop(p, bi);
            if (64'(bsz) > sz) hole_add(p, off[31:0] + sz[31:0], bsz - sz[31:0]);
        end else begin
            pg_tail[p] = pg_tail[p] + sz[31:0];
        end
        pg_used[p] = pg_used[p] + sz[31:0];
        grant_live[slot] = 1'b1;
        grant_page[slot] = 3'(p);
        grant_off[slot]  = off[31:0];
        grant_len[slot]  = sz[31:0];
        y.out_page   = 3'(p);
        y.out_offset = off[31:0];
        y.out_size   = sz[31:0];
        return y;
    endfunction

    function automatic t_rsp release_grant(t_req r);
        t_rsp        y;
        int          merged [NF];
        int          k, n, slot, p;
        logic [63:0] fo, fs, bo, bs;
        bit          retract;
        y = '0;
        slot = NA;
        for (int i = 0; i < NA; i++)
            if (grant_live[i] && grant_page[i] == r.free_page
                    && grant_off[i] == r.free_offset) begin
                slot = i;
                break;
            end
        if (slot == NA) begin
            y.status = ST_UNKNOWN_FREE;
            return y;
        end
        p  = grant_page[slot];
        n  = (pg_holes[p] < NF) ? pg_holes[p] : NF;
        fo = 64'(grant_off[slot]);
        fs = 64'(grant_len[slot]);
        k  = 0;
        for (int i = 0; i < n; i++) begin
            bo = 64'(hole_off[p][i]);
            bs = 64'(hole_len[p][i]);
            if (bo + bs == fo) begin
                fo = bo;
                fs = fs + bs;
                merged[k] = i;
                k++;
            end else if (bo == fo + fs) begin
                fs = fs + bs;
                merged[k] = i;
                k++;
            end
        end
        retract = ((fo + fs) == 64'(pg_tail[p]));
        if (!retract && n - k >= NF) begin
            y.status = ST_LIST_FULL;
            return y;
        end
        for (int i = k; i > 0; i--) hole_drop(p, merged[i-1]);
        if (retract) pg_tail[p] = fo[31:0];
        else         hole_add(p, fo[31:0], fs[31:0]);
        pg_used[p] = pg_used[p] - grant_len[slot];
        grant_live[slot] = 1'b0;
        y.out_page   = r.free_page;
        y.out_offset = r.free_offset;
        y.out_size   = grant_len[slot];
        return y;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            page_bytes_cfg = RESET_PAGE_BYTES;
            min_align_cfg  = RESET_MIN_ALIGN;
            for (int p = 0; p < NP; p++) begin
                pg_open[p] = 1'b0;
                pg_size[p] = '0;
                pg_tail[p] = '0;
                pg_used[p] = '0;
                pg_holes[p] = 0;
                for (int i = 0; i < NF; i++) begin
                    hole_off[p][i] = '0;
                    hole_len[p][i] = '0;
                end
            end
            for (int i = 0; i < NA; i++) begin
                grant_live[i] = 1'b0;
                grant_page[i] = '0;
                grant_off[i]  = '0;
                grant_len[i]  = '0;
            end
            rsp_forecast_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_PAGE_BYTES) page_bytes_cfg = i_cfg_data;
                else                               min_align_cfg  = i_cfg_data[12:0];
            end
            // Responses are checked before new forecasts are queued.
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_forecast_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected response: status %0d page %0d off %h size %h",
                                 i_rsp.status, i_rsp.out_page, i_rsp.out_offset,
                                 i_rsp.out_size);
                end else begin
                    want = rsp_forecast_q.pop_front();
                    if (i_rsp.status !== want.status || i_rsp.out_page !== want.out_page
                            || i_rsp.out_offset !== want.out_offset
                            || i_rsp.out_size !== want.out_size) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: exp st %0d pg %0d off %h sz %h, ",
                                     want.status, want.out_page, want.out_offset,
                                     want.out_size, "got st %0d pg %0d off %h sz %h",
                                     i_rsp.status, i_rsp.out_page,
                                     i_rsp.out_offset, i_rsp.out_size);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                rsp_forecast_q.push_back(i_req.func == FUNC_FREE ? release_grant(i_req)
                                                                 : grant(i_req));
        end
        o_fail_count <= fails;
        o_pending    <= rsp_forecast_q.size();
    end

endmodule

`default_nettype wire

// ===== sim/tb_paged_free_list_allocator_unit.sv =====
// ============================================================================
// tb_paged_free_list_allocator_unit: stimulus and verdict for the allocator
// Drives directed and random allocate and free requests through several
// configurations and flow-control phases; a checker module scores responses.
// ============================================================================
`default_nettype none

module tb_paged_free_list_allocator_unit;
    import pfla_pkg::*;

    // Cycles with no handshake on any channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 96;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_req_valid = 1'b0;
    logic        o_req_ready;
    t_req        i_req = '0;
    logic        o_rsp_valid;
    logic        i_rsp_ready = 1'b0;
    t_rsp        o_rsp;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;

    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          rsp_stall_pct = 0;
    int          quiet_cycles = 0;

    // Keys of granted allocations, learned from responses, used to build
    // well-formed free requests. A burst list tracks one fill sequence.
    logic        func_q[$];
    logic [34:0] live_keys[$];
    logic [34:0] burst_keys[$];
    bit          collect_burst = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    paged_free_list_allocator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    pfla_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req        (i_req),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .i_rsp        (o_rsp),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // The receiver stalls at random at the rate of the current phase.
    always @(posedge i_clk) begin
        i_rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    // Record which function each request had, so that a successful allocate
    // response can add its key to the pool of live allocations.
    always @(posedge i_clk) begin
        logic f;
        if (i_rst_n) begin
            if (o_rsp_valid && i_rsp_ready && func_q.size() > 0) begin
                f = func_q.pop_front();
                if (f == FUNC_ALLOC && o_rsp.status == ST_OK) begin
                    live_keys.push_back({o_rsp.out_page, o_rsp.out_offset});
                    if (collect_burst) burst_keys.push_back({o_rsp.out_page, o_rsp.out_offset});
                end
            end
            if (i_req_valid && o_req_ready) func_q.push_back(i_req.func);
        end
    end

    // Watchdog: any handshake restarts the count.
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[paged_free_list_allocator_unit] ERROR");
                $finish;
            end
        end
    end

    // Present one request, idling first at the sender's rate. Valid is only
    // lowered during an idle gap, so back-to-back requests keep it high.
    task automatic send(t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
    endtask

    // Wait until every request has been answered.
    task automatic drain();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Fields that a request does not use still carry random values.
    function automatic t_req alloc_req(logic [31:0] size, logic [12:0] align);
        t_req r;
        r.func        = FUNC_ALLOC;
        r.req_size    = size;
        r.req_align   = align;
        r.free_page   = 3'($urandom);
        r.free_offset = $urandom;
        return r;
    endfunction

    function automatic t_req free_req(logic [34:0] key);
        t_req r;
        r.func        = FUNC_FREE;
        r.req_size    = $urandom;
        r.req_align   = 13'($urandom);
        r.free_page   = key[34:32];
        r.free_offset = key[31:0];
        return r;
    endfunction

    function automatic logic [34:0] take_key(int idx);
        logic [34:0] k;
        k = live_keys[idx];
        live_keys.delete(idx);
        return k;
    endfunction

    function automatic t_req random_req();
        int          x, y, z;
        logic [31:0] size;
        logic [12:0] align;
        x = $urandom_range(99);
        if (x < 10) begin
            // Noise: a key that is most likely unknown.
            return free_req({3'($urandom), ($urandom_range(1) != 0) ? $urandom
                                                                     : 32'($urandom_range(4095))});
        end
        if (x < 45 && live_keys.size() > 0)
            return free_req(take_key($urandom_range(live_keys.size() - 1)));
        y = $urandom_range(99);
        if (y < 70)      size = $urandom_range(512);
        else if (y < 90) size = $urandom_range(20000);
        else if (y < 97) size = $urandom;
        else             size = 32'hFFFF_FFFF - $urandom_range(8192);
        z = $urandom_range(99);
        if (z < 80)      align = 13'(1) << $urandom_range(12);
        else if (z < 92) align = 13'($urandom);
        else             align = '0;
        return alloc_req(size, align);
    endfunction

    initial begin
        logic [34:0] k0, k1, k2;
        logic [31:0] page_set  [5];
        logic [12:0] align_set [5];
        int          idle_set  [5];
        int          stall_set [5];

        page_set  = '{32'd1, 32'hFFFF_FFFF, 32'd4096, 32'd65536, 32'd300};
        align_set = '{13'd1, 13'd4096, 13'd64, 13'd16, 13'd8};
        idle_set  = '{0, 86, 0, 26, 0};
        stall_set = '{0, 0, 86, 26, 0};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset configuration. Zero alignment and zero size
        // come first; a second zero-size grant lands on the same key.
        send(alloc_req(32'd0, 13'd0));
        send(alloc_req(32'd0, 13'd1));
        send(alloc_req(32'd100, 13'd3));           // alignment not a power of two
        send(alloc_req(32'd1, 13'd4096));
        send(alloc_req(32'hFFFF_FFFF, 13'd1));     // aligned size overflows 32 bits
        send(alloc_req(32'hFFFF_F000, 13'd4096));  // opens an oversized page
        send(alloc_req(32'd48, 13'd16));
        send(alloc_req(32'd48, 13'd16));
        send(alloc_req(32'd48, 13'd16));
        send(alloc_req(32'd4096, 13'h1FFF));
        drain();
        // Free the last three 48-byte grants in address order, so that the
        // freed blocks coalesce into one hole.
        if (live_keys.size() >= 4) begin
            k1 = take_key(live_keys.size() - 3);
            k0 = take_key(live_keys.size() - 3);
            k2 = take_key(live_keys.size() - 2);
            send(free_req(k0));
            send(free_req(k1));
            send(free_req(k2));
            send(free_req(k2));                    // double free
        end
        send(free_req({3'd7, 32'hFFFF_FFFF}));
        send(free_req({3'd0, 32'd0}));
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            cfg_write(CFG_PAGE_BYTES, page_set[ph]);
            cfg_write(CFG_MIN_ALIGN, ($urandom & ~32'h1FFF) | 32'(align_set[ph]));
            send_idle_pct = idle_set[ph];
            rsp_stall_pct = stall_set[ph];
            if (ph == 0 || ph == 4) begin
                // Fill sequence: many small grants, then free every other one
                // so holes pile up until the free list overflows.
                collect_burst = 1'b1;
                burst_keys.delete();
                repeat (40) send(alloc_req(32'($urandom_range(1, 16)), 13'd1));
                drain();
                collect_burst = 1'b0;
                for (int i = 0; i < burst_keys.size(); i += 2) begin
                    for (int j = 0; j < live_keys.size(); j++)
                        if (live_keys[j] == burst_keys[i]) begin
                            live_keys.delete(j);
                            break;
                        end
                    send(free_req(burst_keys[i]));
                end
            end
            repeat (PHASE_ITEMS) send(random_req());
        end

        drain();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[paged_free_list_allocator_unit] OK");
        end else begin
            $display("[paged_free_list_allocator_unit] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/pfla_pkg.sv
rtl/pfla_dpath.sv
rtl/pfla_ctrl.sv
rtl/paged_free_list_allocator_unit.sv
sim/pfla_checker.sv
sim/tb_paged_free_list_allocator_unit.sv
